// ----- hdl/nhrb_pkg.sv -----
package nhrb_pkg;

   // Command codes carried on the request opcode field.
   localparam logic [2:0] OP_ADD   = 3'd0;
   localparam logic [2:0] OP_NEXT  = 3'd1;
   localparam logic [2:0] OP_BACK  = 3'd2;
   localparam logic [2:0] OP_FWD   = 3'd3;
   localparam logic [2:0] OP_QUERY = 3'd4;

   localparam int OPCODE_W   = 3;
   localparam int PREFETCH_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 2;

   localparam logic [PREFETCH_W-1:0] PREFETCH_RESET = 5'd4;

   // Register map.
   localparam logic [CSR_ADDR_W-1:0] REG_PREFETCH_DEPTH = 2'd0;

   // Decision taken by the cursor logic for one accepted item.
   typedef struct packed {
      logic hit;
      logic mem_wr;
      logic refill_wanted;
   } cur_result_type;

endpackage

// ----- hdl/nhrb_cursor.sv -----
module nhrb_cursor
   import nhrb_pkg::*;
#(
   parameter int DEPTH  = 16,
   parameter int SLOT_W = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic [OPCODE_W-1:0]   opcode,
   input  logic                  entry_present,
   input  logic [PREFETCH_W-1:0] prefetch_depth,
   output cur_result_type        result,
   output logic [SLOT_W-1:0]     mem_addr,
   output logic [SLOT_W-1:0]     view_position,
   output logic [SLOT_W-1:0]     unseen_count
);

   localparam int CNT_W = SLOT_W + 1;
   localparam int CMP_W = (SLOT_W > PREFETCH_W) ? SLOT_W : PREFETCH_W;
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(DEPTH - 1);

   logic [SLOT_W-1:0] newest_ff, newest_in;
   logic [SLOT_W-1:0] seen_ff, seen_in;
   logic [SLOT_W-1:0] view_ff, view_in;
   logic              view_valid_ff, view_valid_in;
   logic [SLOT_W-1:0] unseen_now;
   logic [SLOT_W-1:0] prev_slot;

   function automatic logic [SLOT_W-1:0] step_up(input logic [SLOT_W-1:0] s);
      return (s == LAST_SLOT) ? '0 : s + SLOT_W'(1);
   endfunction

   function automatic logic [SLOT_W-1:0] step_down(input logic [SLOT_W-1:0] s);
      return (s == '0) ? LAST_SLOT : s - SLOT_W'(1);
   endfunction

   // Distance from the seen cursor up to the newest cursor around the ring.
   function automatic logic [SLOT_W-1:0] distance(input logic [SLOT_W-1:0] t,
                                                  input logic [SLOT_W-1:0] l);
      logic [CNT_W-1:0] d;
      d = {1'b0, t} - {1'b0, l};
      if (t < l) begin
         d = d + CNT_W'(DEPTH);
      end
      return d[SLOT_W-1:0];
   endfunction

   assign unseen_now = distance(newest_ff, seen_ff);
   assign prev_slot  = step_down(view_ff);

   always_comb begin
      newest_in     = newest_ff;
      seen_in       = seen_ff;
      view_in       = view_ff;
      view_valid_in = view_valid_ff;
      result        = '0;
      mem_addr      = newest_ff;
      unique case (opcode)
         OP_ADD: begin
            if (entry_present) begin
               newest_in     = step_up(newest_ff);
               mem_addr      = newest_in;
               result.mem_wr = 1'b1;
            end
         end
         OP_NEXT: begin
            if (unseen_now != '0) begin
               seen_in       = step_up(seen_ff);
               view_in       = seen_in;
               view_valid_in = 1'b1;
               result.hit    = 1'b1;
            end
         end
         OP_BACK: begin
            if (view_valid_ff && (prev_slot != newest_ff)) begin
               view_in    = prev_slot;
               result.hit = 1'b1;
            end
         end
         OP_FWD: begin
            if (view_valid_ff && (view_ff != seen_ff)) begin
               view_in    = step_up(view_ff);
               result.hit = 1'b1;
            end
         end
         default: begin
         end
      endcase
      if (result.hit) begin
         mem_addr = view_in;
      end
      unseen_count         = distance(newest_in, seen_in);
      result.refill_wanted = CMP_W'(unseen_count) < CMP_W'(prefetch_depth);
      view_position        = view_valid_in ? view_in : '0;
   end

   // After reset the newest and seen cursors stand on the slot below slot 0.
   always_ff @(posedge clock) begin
      if (reset) begin
         newest_ff     <= LAST_SLOT;
         seen_ff       <= LAST_SLOT;
         view_ff       <= LAST_SLOT;
         view_valid_ff <= 1'b0;
      end else if (accept) begin
         newest_ff     <= newest_in;
         seen_ff       <= seen_in;
         view_ff       <= view_in;
         view_valid_ff <= view_valid_in;
      end
   end

endmodule

// ----- hdl/navigable_history_ring_buffer.sv -----
// Channel   Direction  Handshake                 Payload
// req_      in         req_valid / req_ready     opcode, entry_data, entry_present
// rsp_      out        rsp_valid / rsp_ready     hit, entry_out, view_position,
//                                                unseen_count, refill_wanted
// csr_      in         APB, pready always high   prefetch_depth at byte address 0
//
// One item is accepted per cycle while the result side keeps up; its result
// passes through the registered memory read and then the output register.
// The cursors move at the accepting edge, so the next item sees them.
// A stalled result holds the output register and then the pending stage;
// req_ready falls only when both are full. Reset empties the cursors and sets
// the prefetch depth to four; the entry memory is never cleared.
module navigable_history_ring_buffer
   import nhrb_pkg::*;
#(
   parameter int DEPTH       = 16,
   parameter int ENTRY_WIDTH = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [OPCODE_W-1:0]     req_opcode,
   input  logic [ENTRY_WIDTH-1:0]  req_entry_data,
   input  logic                    req_entry_present,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic                    rsp_hit,
   output logic [ENTRY_WIDTH-1:0]  rsp_entry_out,
   output logic [$clog2(DEPTH)-1:0] rsp_view_position,
   output logic [$clog2(DEPTH)-1:0] rsp_unseen_count,
   output logic                    rsp_refill_wanted,
   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [CSR_DATA_W-1:0]   csr_pwdata,
   output logic [CSR_DATA_W-1:0]   csr_prdata,
   output logic                    csr_pready
);

   localparam int SLOT_W = $clog2(DEPTH);

   logic [PREFETCH_W-1:0] prefetch_ff;
   logic                  accept;
   logic                  out_take;
   cur_result_type        cur_result;
   logic [SLOT_W-1:0]     mem_addr;
   logic [SLOT_W-1:0]     cur_view;
   logic [SLOT_W-1:0]     cur_unseen;

   // The entry ring itself.
   logic [ENTRY_WIDTH-1:0] store_mem [DEPTH];
   logic [ENTRY_WIDTH-1:0] rd_data_ff;

   // Pending stage: cursor results wait here while the memory read completes.
   logic              pend_valid_ff;
   logic              pend_hit_ff;
   logic              pend_refill_ff;
   logic [SLOT_W-1:0] pend_view_ff;
   logic [SLOT_W-1:0] pend_unseen_ff;

   // Output register.
   logic                   rsp_valid_ff;
   logic                   rsp_hit_ff;
   logic                   rsp_refill_ff;
   logic [ENTRY_WIDTH-1:0] rsp_entry_ff;
   logic [SLOT_W-1:0]      rsp_view_ff;
   logic [SLOT_W-1:0]      rsp_unseen_ff;

   // Config register. Writes must arrive while the block is idle; not enforced.
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == REG_PREFETCH_DEPTH) ?
                       CSR_DATA_W'(prefetch_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         prefetch_ff <= PREFETCH_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
                   (csr_paddr == REG_PREFETCH_DEPTH)) begin
         prefetch_ff <= csr_pwdata[PREFETCH_W-1:0];
      end
   end

   // The output register frees up when its item is taken; the pending stage
   // moves on whenever the output register can take it.
   assign out_take  = !rsp_valid_ff || rsp_ready;
   assign req_ready = !pend_valid_ff || out_take;
   assign accept    = req_valid && req_ready;

   nhrb_cursor #(
      .DEPTH  (DEPTH),
      .SLOT_W (SLOT_W)
   ) u_cursor (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .opcode         (req_opcode),
      .entry_present  (req_entry_present),
      .prefetch_depth (prefetch_ff),
      .result         (cur_result),
      .mem_addr       (mem_addr),
      .view_position  (cur_view),
      .unseen_count   (cur_unseen)
   );

   // A single port is enough: an item either writes a new entry or reads the
   // entry it now views, never both. A read in the cycle after a write to the
   // same slot already sees the new entry, so no forwarding is needed.
   always_ff @(posedge clock) begin
      if (accept && cur_result.mem_wr) begin
         store_mem[mem_addr] <= req_entry_data;
      end
      if (accept && cur_result.hit) begin
         rd_data_ff <= store_mem[mem_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
      end else if (accept) begin
         pend_valid_ff <= 1'b1;
      end else if (out_take) begin
         pend_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pend_hit_ff    <= cur_result.hit;
         pend_refill_ff <= cur_result.refill_wanted;
         pend_view_ff   <= cur_view;
         pend_unseen_ff <= cur_unseen;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_take) begin
         rsp_valid_ff <= pend_valid_ff;
      end
   end

   // A miss returns a zero entry.
   always_ff @(posedge clock) begin
      if (out_take && pend_valid_ff) begin
         rsp_hit_ff    <= pend_hit_ff;
         rsp_refill_ff <= pend_refill_ff;
         rsp_entry_ff  <= pend_hit_ff ? rd_data_ff : '0;
         rsp_view_ff   <= pend_view_ff;
         rsp_unseen_ff <= pend_unseen_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_hit           = rsp_hit_ff;
   assign rsp_entry_out     = rsp_entry_ff;
   assign rsp_view_position = rsp_view_ff;
   assign rsp_unseen_count  = rsp_unseen_ff;
   assign rsp_refill_wanted = rsp_refill_ff;

   // A hit must reach the pending stage together with its memory read.
   a_hit_reaches_pending: assert property (@(posedge clock) disable iff (reset)
      (accept && cur_result.hit) |=> (pend_valid_ff && pend_hit_ff))
      else $error("hit item did not reach the pending stage");

   // Only an add that carries an entry may write the ring.
   a_write_only_on_add: assert property (@(posedge clock) disable iff (reset)
      (accept && cur_result.mem_wr) |-> (req_opcode == OP_ADD && req_entry_present))
      else $error("memory written by an item that is not an add with an entry");

   // The unseen count is a distance around the ring and stays below its depth.
   a_unseen_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((SLOT_W + 1)'(rsp_unseen_ff) < (SLOT_W + 1)'(DEPTH)))
      else $error("unseen count outside the ring");

endmodule

// ----- tb/testbench.sv -----
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import nhrb_pkg::*;

   // The history ring holds sixteen entries of 32 bits, so every slot index and the
   // unseen count fit in four bits. A cursor carries one extra bit; all ones means
   // that the cursor points at nothing yet.
   localparam int HIST_DEPTH = 16;
   localparam int DATA_W     = 32;
   localparam int SLOT_W     = 4;
   localparam logic [SLOT_W:0] NO_CURSOR = '1;

   // The block treats the three spare opcodes as a refill query.
   localparam logic [OPCODE_W-1:0] OP_SPARE_LO = 3'd5;
   localparam logic [OPCODE_W-1:0] OP_SPARE_HI = 3'd7;

   localparam int PHASE_COUNT      = 6;
   localparam int ITEMS_PER_PHASE  = 325;
   localparam int LONG_HOLD_CYCLES = 48;
   localparam int SETTLE_CYCLES    = 6;

   // One result item as the block should present it.
   typedef struct packed {
      logic                hit;
      logic [DATA_W-1:0]   entry;
      logic [SLOT_W-1:0]   view;
      logic [SLOT_W-1:0]   unseen;
      logic                refill;
   } view_result_type;

   // One row of the directed table. Where typed is set, the row carries its own
   // result, read straight off the behaviour; otherwise the predictor supplies it.
   typedef struct packed {
      logic [OPCODE_W-1:0] op;
      logic [DATA_W-1:0]   data;
      logic                present;
      bit                  typed;
      view_result_type     result;
   } stim_row_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic [OPCODE_W-1:0]   req_opcode;
   logic [DATA_W-1:0]     req_entry_data;
   logic                  req_entry_present;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic                  rsp_hit;
   logic [DATA_W-1:0]     rsp_entry_out;
   logic [SLOT_W-1:0]     rsp_view_position;
   logic [SLOT_W-1:0]     rsp_unseen_count;
   logic                  rsp_refill_wanted;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // Shadow copy of the ring and its cursors, advanced once per accepted item.
   logic [DATA_W-1:0]     entry_mem [HIST_DEPTH];
   bit   [HIST_DEPTH-1:0] slot_filled;
   logic [SLOT_W:0]       newest_cur;
   logic [SLOT_W:0]       seen_cur;
   logic [SLOT_W:0]       view_cur;
   logic [PREFETCH_W-1:0] prefetch_cfg;

   view_result_type pending_views [$];
   stim_row_type    directed_rows [$];
   int              fault_count;
   bit              hold_request;
   bit              calm;

   navigable_history_ring_buffer DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_opcode        (req_opcode),
      .req_entry_data    (req_entry_data),
      .req_entry_present (req_entry_present),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_hit           (rsp_hit),
      .rsp_entry_out     (rsp_entry_out),
      .rsp_view_position (rsp_view_position),
      .rsp_unseen_count  (rsp_unseen_count),
      .rsp_refill_wanted (rsp_refill_wanted),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // A cursor that points at nothing behaves, for distance and stepping, as the
   // slot just below slot zero, which is the top slot of the ring.
   function automatic logic [SLOT_W-1:0] slot_of(input logic [SLOT_W:0] cursor);
      return (cursor < HIST_DEPTH) ? cursor[SLOT_W-1:0] : SLOT_W'(HIST_DEPTH - 1);
   endfunction

   // Four-bit subtraction wraps, which is exactly the distance modulo the depth;
   // a whole lap of adds therefore reads as zero.
   function automatic logic [SLOT_W-1:0] unseen_now();
      return slot_of(newest_cur) - slot_of(seen_cur);
   endfunction

   // True when the command would move the view onto a slot that no add has
   // written yet. The contents of such a slot are undefined, so the stimulus
   // never asks for one.
   function automatic bit would_view_unwritten(input logic [OPCODE_W-1:0] op);
      logic [SLOT_W-1:0] dest;
      bit                blank;
      blank = 1'b0;
      case (op)
         OP_NEXT: begin
            dest  = slot_of(seen_cur) + SLOT_W'(1);
            blank = unseen_now() != '0 && !slot_filled[dest];
         end
         OP_BACK: begin
            dest  = view_cur[SLOT_W-1:0] - SLOT_W'(1);
            blank = !view_cur[SLOT_W] && dest != slot_of(newest_cur) && !slot_filled[dest];
         end
         OP_FWD: begin
            dest  = view_cur[SLOT_W-1:0] + SLOT_W'(1);
            blank = !view_cur[SLOT_W] && view_cur[SLOT_W-1:0] != slot_of(seen_cur)
                    && !slot_filled[dest];
         end
         default: blank = 1'b0;
      endcase
      return blank;
   endfunction

   // Applies one command to the shadow ring and returns the result item that the
   // block should give for it.
   function automatic view_result_type advance_history(input logic [OPCODE_W-1:0] op,
                                                       input logic [DATA_W-1:0] data,
                                                       input logic present);
      view_result_type   r;
      logic [SLOT_W-1:0] dest;
      r = '0;
      case (op)
         OP_ADD: if (present) begin
            // An add without an entry is dropped and changes nothing.
            dest              = slot_of(newest_cur) + SLOT_W'(1);
            newest_cur        = {1'b0, dest};
            entry_mem[dest]   = data;
            slot_filled[dest] = 1'b1;
         end
         OP_NEXT: if (unseen_now() != '0) begin
            dest     = slot_of(seen_cur) + SLOT_W'(1);
            seen_cur = {1'b0, dest};
            view_cur = seen_cur;
            r.hit    = 1'b1;
         end
         OP_BACK: begin
            // Stepping down onto the newest slot would show the overwrite point,
            // so the view stays put.
            dest = view_cur[SLOT_W-1:0] - SLOT_W'(1);
            if (!view_cur[SLOT_W] && dest != slot_of(newest_cur)) begin
               view_cur = {1'b0, dest};
               r.hit    = 1'b1;
            end
         end
         OP_FWD: begin
            dest = view_cur[SLOT_W-1:0] + SLOT_W'(1);
            if (!view_cur[SLOT_W] && view_cur[SLOT_W-1:0] != slot_of(seen_cur)) begin
               view_cur = {1'b0, dest};
               r.hit    = 1'b1;
            end
         end
         default: ;
      endcase
      if (r.hit) begin
         r.entry = entry_mem[view_cur[SLOT_W-1:0]];
      end
      r.view   = view_cur[SLOT_W] ? '0 : view_cur[SLOT_W-1:0];
      r.unseen = unseen_now();
      r.refill = {1'b0, r.unseen} < prefetch_cfg;
      return r;
   endfunction

   task automatic add_row(input logic [OPCODE_W-1:0] op, input logic [DATA_W-1:0] data,
                          input logic present, input bit typed, input logic hit,
                          input logic [DATA_W-1:0] entry, input logic [SLOT_W-1:0] view,
                          input logic [SLOT_W-1:0] unseen, input logic refill);
      stim_row_type row;
      row.op      = op;
      row.data    = data;
      row.present = present;
      row.typed   = typed;
      row.result  = {hit, entry, view, unseen, refill};
      directed_rows.push_back(row);
   endtask

   // Offers one item at the falling edge and holds it until the block takes it.
   // The expectation is queued at the accepting edge; the result cannot appear
   // before the following edge, so the checker always finds it in time.
   task automatic send_item(input logic [OPCODE_W-1:0] op, input logic [DATA_W-1:0] data,
                            input logic present, input bit typed,
                            input view_result_type typed_result);
      view_result_type predicted;
      @(negedge clock);
      req_valid         <= 1'b1;
      req_opcode        <= op;
      req_entry_data    <= data;
      req_entry_present <= present;
      do @(posedge clock); while (!req_ready);
      predicted = advance_history(op, data, present);
      pending_views.push_back(typed ? typed_result : predicted);
   endtask

   task automatic sender_pause(input int cycles);
      repeat (cycles) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
   endtask

   // Stops offering items and waits until every outstanding result has been
   // collected, then lets the pipeline settle.
   task automatic await_quiet(input int settle);
      sender_pause(1);
      while (pending_views.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   // Writes the prefetch depth through the register port, then reads it back.
   task automatic write_prefetch(input int value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= REG_PREFETCH_DEPTH;
      csr_pwdata  <= CSR_DATA_W'(value);
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      prefetch_cfg = PREFETCH_W'(value);
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== CSR_DATA_W'(value)) begin
         $error("prefetch_depth readback: expected %0d, got %0d", value, csr_prdata);
         fault_count++;
      end
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Result side. It stalls in short random bursts, takes a single long break when
   // the stimulus asks for one (so that both internal stages fill and the input
   // side backs up), and stops stalling altogether once the run turns calm.
   initial begin : result_sink
      int n;
      rsp_ready = 1'b0;
      wait (reset == 1'b0);
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            for (n = 0; n < LONG_HOLD_CYCLES; n++) begin
               @(negedge clock);
               rsp_ready <= 1'b0;
            end
         end else if (!calm && $urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 9)) begin
               @(negedge clock);
               rsp_ready <= 1'b0;
            end
         end else begin
            repeat ($urandom_range(1, 24)) begin
               @(negedge clock);
               rsp_ready <= 1'b1;
            end
         end
      end
   end

   // Every result taken from the block is matched against the oldest expectation.
   always @(posedge clock) begin : result_check
      view_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_views.size() == 0) begin
            $error("result item arrived with no command outstanding");
            fault_count++;
         end else begin
            want = pending_views.pop_front();
            if (rsp_hit !== want.hit) begin
               $error("hit: expected %0d, got %0d", want.hit, rsp_hit);
               fault_count++;
            end
            if (rsp_entry_out !== want.entry) begin
               $error("entry_out: expected %h, got %h", want.entry, rsp_entry_out);
               fault_count++;
            end
            if (rsp_view_position !== want.view) begin
               $error("view_position: expected %0d, got %0d", want.view, rsp_view_position);
               fault_count++;
            end
            if (rsp_unseen_count !== want.unseen) begin
               $error("unseen_count: expected %0d, got %0d", want.unseen, rsp_unseen_count);
               fault_count++;
            end
            if (rsp_refill_wanted !== want.refill) begin
               $error("refill_wanted: expected %0d, got %0d", want.refill,
                      rsp_refill_wanted);
               fault_count++;
            end
         end
      end
   end

   initial begin : stimulus
      logic [OPCODE_W-1:0] op;
      logic [DATA_W-1:0]   data;
      logic                present;
      int                  ph;
      int                  k;
      int                  done;
      int                  sent;
      int                  depth_set;
      int                  add_pct;
      stim_row_type        row;

      reset             = 1'b1;
      req_valid         = 1'b0;
      req_opcode        = OP_QUERY;
      req_entry_data    = '0;
      req_entry_present = 1'b0;
      csr_psel          = 1'b0;
      csr_penable       = 1'b0;
      csr_pwrite        = 1'b0;
      csr_paddr         = REG_PREFETCH_DEPTH;
      csr_pwdata        = '0;
      fault_count       = 0;
      hold_request      = 1'b0;
      calm              = 1'b0;
      newest_cur        = NO_CURSOR;
      seen_cur          = NO_CURSOR;
      view_cur          = NO_CURSOR;
      slot_filled       = '0;
      prefetch_cfg      = PREFETCH_RESET;

      // Straight after reset the ring is empty: nothing to step through, nothing
      // unseen, and with the reset prefetch depth of four a refill is wanted.
      add_row(OP_BACK,     '0, 1'b0, 1'b1, 1'b0, '0, '0, '0, 1'b1);
      add_row(OP_FWD,      '1, 1'b1, 1'b1, 1'b0, '0, '0, '0, 1'b1);
      add_row(OP_NEXT,     '0, 1'b1, 1'b1, 1'b0, '0, '0, '0, 1'b1);
      add_row(OP_QUERY,    '1, 1'b0, 1'b1, 1'b0, '0, '0, '0, 1'b1);
      // An add without an entry must leave the ring untouched.
      add_row(OP_ADD,      '1, 1'b0, 1'b1, 1'b0, '0, '0, '0, 1'b1);
      add_row(OP_SPARE_HI, '1, 1'b1, 1'b1, 1'b0, '0, '0, '0, 1'b1);
      // First entry lands in slot zero and is then viewed.
      add_row(OP_ADD,      '1, 1'b1, 1'b1, 1'b0, '0, '0, 4'd1, 1'b1);
      add_row(OP_NEXT,     '0, 1'b0, 1'b1, 1'b1, '1, '0, '0, 1'b1);
      // Fill the rest of the ring, leaving fifteen entries unseen.
      for (k = 1; k < HIST_DEPTH; k++) begin
         add_row(OP_ADD, (k == 1) ? '0 : DATA_W'($urandom), 1'b1, 1'b0, 1'b0, '0, '0, '0,
                 1'b0);
      end
      // The slot below the view is now the newest one, so back must refuse, and
      // forward must refuse because the view already sits on the seen slot.
      add_row(OP_BACK,     '0, 1'b1, 1'b1, 1'b0, '0, '0, 4'd15, 1'b0);
      add_row(OP_FWD,      '0, 1'b1, 1'b1, 1'b0, '0, '0, 4'd15, 1'b0);
      // One more add completes a whole lap, which reads as nothing unseen.
      add_row(OP_ADD,      32'h0000_0001, 1'b1, 1'b1, 1'b0, '0, '0, '0, 1'b1);

      repeat (11) @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         if ($urandom_range(0, 3) == 0) begin
            sender_pause($urandom_range(1, 9));
         end
         send_item(row.op, row.data, row.present, row.typed, row.result);
      end
      await_quiet(SETTLE_CYCLES);

      // Random phases. Each one sets a prefetch depth, the extremes among them,
      // and a share of adds: add-heavy phases lap the ring repeatedly, while
      // navigation-heavy ones walk the view back and forth across many slots.
      for (ph = 0; ph < PHASE_COUNT; ph++) begin
         case (ph)
            0:       begin depth_set = 16; add_pct = 35; end
            1:       begin depth_set = 0;  add_pct = 60; end
            2:       begin depth_set = 1;  add_pct = 20; end
            3:       begin depth_set = 9;  add_pct = 45; end
            4:       begin depth_set = $urandom_range(0, 16); add_pct = 40; end
            default: begin depth_set = 15; add_pct = 40; end
         endcase
         write_prefetch(depth_set);
         // The final phase runs with no idling on either side.
         calm = (ph == PHASE_COUNT - 1);
         done = 0;
         sent = 0;
         while (done < ITEMS_PER_PHASE) begin
            // In one phase the result side takes a long break while items keep
            // coming, and later the input side waits for everything to drain.
            if (ph == 3 && sent == 100) begin
               hold_request = 1'b1;
            end
            if (ph == 3 && sent == 200) begin
               await_quiet(0);
            end
            if (!calm && $urandom_range(0, 3) == 0) begin
               sender_pause($urandom_range(1, 9));
            end

            if ($urandom_range(0, 99) < add_pct) begin
               op = OP_ADD;
            end else begin
               case ($urandom_range(0, 9))
                  0, 1, 2: op = OP_NEXT;
                  3, 4, 5: op = OP_BACK;
                  6, 7:    op = OP_FWD;
                  8:       op = OP_QUERY;
                  default: op = OPCODE_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
               endcase
            end
            case ($urandom_range(0, 7))
               0:       data = '0;
               1:       data = '1;
               default: data = DATA_W'($urandom);
            endcase
            present = ($urandom_range(0, 11) != 0);
            // Before the first lap, a step could land on a slot that has never
            // been written; an add is sent in its place.
            if (would_view_unwritten(op)) begin
               op      = OP_ADD;
               present = 1'b1;
            end

            send_item(op, data, present, 1'b0, '0);
            sent++;
            if (!(op == OP_ADD && !present)) begin
               done++;
            end
         end
         await_quiet(SETTLE_CYCLES);
      end

      await_quiet(8);
      if (fault_count == 0) begin
         $display("navigable_history_ring_buffer verification clean");
      end else begin
         $display("navigable_history_ring_buffer verification failed");
      end
      $finish;
   end

   // Far beyond the slowest correct run: every item meeting the longest gap on
   // both sides still finishes well inside this.
   initial begin : watchdog
      #(4_000_000);
      $display("navigable_history_ring_buffer verification failed");
      $finish;
   end

endmodule
